/* rtl/core/vpin_order_flow_toxicity_unit_defines.svh */
// Assertion macros shared by the VPIN toxicity unit RTL.
`ifndef VPIN_ORDER_FLOW_TOXICITY_UNIT_DEFINES_SVH
`define VPIN_ORDER_FLOW_TOXICITY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define VPIN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vpin assertion failed");

// Next-cycle implication, checked outside reset.
`define VPIN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vpin assertion failed");

`else

`define VPIN_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VPIN_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/vpin_pkg.sv */
// Shared constants and types of the VPIN toxicity unit.
`timescale 1ns / 1ps
`default_nettype none

package vpin_pkg;

   localparam int QUANTITY_BITS    = 32;
   localparam int FRACTION_BITS    = 16;
   localparam int BUCKET_SIZE_BITS = 12;
   localparam int COUNT_BITS       = 32;

   // Bucket volume holds a full bucket of maximum quantities.
   localparam int VOL_BITS   = QUANTITY_BITS + BUCKET_SIZE_BITS;
   localparam int SUM_BITS   = FRACTION_BITS + COUNT_BITS;
   localparam int QUOT_BITS  = FRACTION_BITS + 1;
   localparam int DIV_BITS   = (VOL_BITS > COUNT_BITS) ? VOL_BITS : COUNT_BITS;
   localparam int STEP_BITS  = $clog2(QUOT_BITS + 1);

   localparam logic [BUCKET_SIZE_BITS-1:0] BUCKET_SIZE_RESET = BUCKET_SIZE_BITS'(50);
   localparam logic [QUOT_BITS-1:0]        ONE_FRAC  = {1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic [COUNT_BITS-1:0]       COUNT_MAX = '1;
   localparam logic [SUM_BITS-1:0]         SUM_MAX   = '1;
   localparam logic [STEP_BITS-1:0]        FRAC_STEPS = STEP_BITS'(FRACTION_BITS);
   localparam logic [STEP_BITS-1:0]        MEAN_STEPS = STEP_BITS'(QUOT_BITS);

   typedef struct packed {
      logic start;
      logic mean_mode;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

/* rtl/core/vpin_divider.sv */
// Shared restoring divider, one quotient bit per cycle, clamped to 1.0.
`timescale 1ns / 1ps
`default_nettype none

`include "vpin_order_flow_toxicity_unit_defines.svh"

module vpin_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  vpin_pkg::div_req_type              req,
   input  logic [vpin_pkg::DIV_BITS-1:0]      dividend_hi,
   input  logic [vpin_pkg::QUOT_BITS-1:0]     dividend_lo,
   input  logic [vpin_pkg::DIV_BITS-1:0]      divisor,
   output vpin_pkg::div_status_type           status,
   output logic [vpin_pkg::QUOT_BITS-1:0]     quotient
);
   import vpin_pkg::*;

   typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_DONE} div_state_type;

   div_state_type          state_ff, state_in;
   logic [DIV_BITS-1:0]    rem_ff, rem_in;
   logic [DIV_BITS-1:0]    divisor_ff, divisor_in;
   logic [QUOT_BITS-1:0]   lo_ff, lo_in;
   logic [QUOT_BITS-1:0]   quot_ff, quot_in;
   logic [STEP_BITS-1:0]   steps_ff, steps_in;

   logic [DIV_BITS:0]      trial;
   logic [DIV_BITS+1:0]    trial_diff;
   logic                   take;

   // Shift in the next dividend bit and try the subtract
   assign trial      = {rem_ff, lo_ff[QUOT_BITS-1]};
   assign trial_diff = {1'b0, trial} - {2'b00, divisor_ff};
   assign take       = ~trial_diff[DIV_BITS+1];

   // Sequence the steps
   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      lo_in      = lo_ff;
      quot_in    = quot_ff;
      steps_in   = steps_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (req.start) begin
               divisor_in = divisor;
               rem_in     = dividend_hi;
               lo_in      = dividend_lo;
               quot_in    = '0;
               steps_in   = req.mean_mode ? MEAN_STEPS : FRAC_STEPS;
               // quotient would reach or pass one: saturate at once
               if (dividend_hi >= divisor) begin
                  quot_in  = ONE_FRAC;
                  state_in = DIV_DONE;
               end else begin
                  state_in = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            rem_in   = take ? trial_diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            lo_in    = {lo_ff[QUOT_BITS-2:0], 1'b0};
            quot_in  = {quot_ff[QUOT_BITS-2:0], take};
            steps_in = steps_ff - STEP_BITS'(1);
            if (steps_ff == STEP_BITS'(1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   // Hold state and operands
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         steps_ff <= steps_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      lo_ff      <= lo_in;
      quot_ff    <= quot_in;
   end

   assign status.busy = (state_ff != DIV_IDLE);
   assign status.done = (state_ff == DIV_DONE);
   assign quotient    = (quot_ff > ONE_FRAC) ? ONE_FRAC : quot_ff;

   `VPIN_ASSERT_IMPLY(a_rem_below_divisor, clock, reset, state_ff == DIV_RUN, rem_ff < divisor_ff)
   `VPIN_ASSERT_IMPLY(a_run_has_steps, clock, reset, state_ff == DIV_RUN, steps_ff != '0)
   `VPIN_ASSERT_IMPLY(a_quot_in_range, clock, reset, status.done, quotient <= ONE_FRAC)

endmodule

`default_nettype wire

/* rtl/core/vpin_order_flow_toxicity_unit.sv */
// Top level of the VPIN order flow toxicity unit: sequencer and bucket state.
`timescale 1ns / 1ps
`default_nettype none

// Trades enter one beat at a time and are grouped into buckets of csr_write_data
// trades (a size of zero acts as one). A trade that closes a bucket keeps req_stall
// high until the bucket is settled, using the shared restoring divider for the
// fraction when the bucket has volume, and a trade that ends the sequence also holds
// it through the mean before its result beat is loaded. The divider produces one
// quotient bit per cycle. The result sits in an output register, so the next
// sequence may start while it waits on rsp_stall. Write the bucket size only while
// the unit is idle.
`include "vpin_order_flow_toxicity_unit_defines.svh"

module vpin_order_flow_toxicity_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [vpin_pkg::BUCKET_SIZE_BITS-1:0]    csr_write_data,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_trade_side,
   input  logic [vpin_pkg::QUANTITY_BITS-1:0]       req_trade_quantity,
   input  logic                                     req_last_trade,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [vpin_pkg::QUOT_BITS-1:0]           rsp_vpin,
   output logic [vpin_pkg::COUNT_BITS-1:0]          rsp_full_buckets,
   output logic [vpin_pkg::COUNT_BITS-1:0]          rsp_counted_buckets,
   output logic                                     rsp_too_few_trades
);
   import vpin_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TOTAL, ST_DIFF, ST_FRAC_START, ST_FRAC_WAIT,
      ST_MEAN_START, ST_MEAN_WAIT, ST_EMIT
   } seq_state_type;

   seq_state_type                  state_ff, state_in;
   logic [BUCKET_SIZE_BITS-1:0]    size_ff, size_in;
   logic [VOL_BITS-1:0]            buy_ff, buy_in;
   logic [VOL_BITS-1:0]            sell_ff, sell_in;
   logic [BUCKET_SIZE_BITS-1:0]    trades_ff, trades_in;
   logic [SUM_BITS-1:0]            imb_ff, imb_in;
   logic [COUNT_BITS-1:0]          full_ff, full_in;
   logic [COUNT_BITS-1:0]          counted_ff, counted_in;
   logic                           last_ff, last_in;
   logic [VOL_BITS-1:0]            total_ff, total_in;
   logic [VOL_BITS-1:0]            diff_ff, diff_in;
   logic [QUOT_BITS-1:0]           mean_ff, mean_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [QUOT_BITS-1:0]           rsp_vpin_ff, rsp_vpin_in;
   logic [COUNT_BITS-1:0]          rsp_full_ff, rsp_full_in;
   logic [COUNT_BITS-1:0]          rsp_counted_ff, rsp_counted_in;
   logic                           rsp_too_few_ff, rsp_too_few_in;

   logic                           req_beat;
   logic [BUCKET_SIZE_BITS-1:0]    size_eff;
   logic [BUCKET_SIZE_BITS:0]      count_inc;
   logic                           bucket_close;
   logic [VOL_BITS-1:0]            qty_ext;
   logic [VOL_BITS:0]              buy_minus_sell;
   logic [SUM_BITS:0]              imb_add;
   logic                           rsp_free;

   div_req_type                    div_req;
   div_status_type                 div_status;
   logic [DIV_BITS-1:0]            div_hi;
   logic [QUOT_BITS-1:0]           div_lo;
   logic [DIV_BITS-1:0]            div_divisor;
   logic [QUOT_BITS-1:0]           div_quotient;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // Bucket bookkeeping for the incoming trade
   assign size_eff       = (size_ff == '0) ? BUCKET_SIZE_BITS'(1) : size_ff;
   assign count_inc      = {1'b0, trades_ff} + (BUCKET_SIZE_BITS + 1)'(1);
   assign bucket_close   = (count_inc >= {1'b0, size_eff});
   assign qty_ext        = VOL_BITS'(req_trade_quantity);
   assign buy_minus_sell = {1'b0, buy_ff} - {1'b0, sell_ff};
   assign imb_add        = {1'b0, imb_ff} + (SUM_BITS + 1)'(div_quotient);

   // Steer the shared divider: bucket fraction or sequence mean
   always_comb begin
      div_req.start     = (state_ff == ST_FRAC_START) ||
                          ((state_ff == ST_MEAN_START) && (counted_ff != '0));
      div_req.mean_mode = (state_ff == ST_MEAN_START);
      if (div_req.mean_mode) begin
         div_hi      = DIV_BITS'(imb_ff[SUM_BITS-1:QUOT_BITS]);
         div_lo      = imb_ff[QUOT_BITS-1:0];
         div_divisor = DIV_BITS'(counted_ff);
      end else begin
         div_hi      = DIV_BITS'(diff_ff);
         div_lo      = '0;
         div_divisor = DIV_BITS'(total_ff);
      end
   end

   vpin_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .req         (div_req),
      .dividend_hi (div_hi),
      .dividend_lo (div_lo),
      .divisor     (div_divisor),
      .status      (div_status),
      .quotient    (div_quotient)
   );

   // Sequence one trade
   always_comb begin
      state_in       = state_ff;
      size_in        = size_ff;
      buy_in         = buy_ff;
      sell_in        = sell_ff;
      trades_in      = trades_ff;
      imb_in         = imb_ff;
      full_in        = full_ff;
      counted_in     = counted_ff;
      last_in        = last_ff;
      total_in       = total_ff;
      diff_in        = diff_ff;
      mean_in        = mean_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_vpin_in    = rsp_vpin_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_counted_in = rsp_counted_ff;
      rsp_too_few_in = rsp_too_few_ff;

      if (csr_write_enable) begin
         size_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_trade_side) begin
                  sell_in = sell_ff + qty_ext;
               end else begin
                  buy_in = buy_ff + qty_ext;
               end
               last_in = req_last_trade;
               if (bucket_close) begin
                  trades_in = '0;
                  full_in   = (full_ff == COUNT_MAX) ? full_ff : full_ff + COUNT_BITS'(1);
                  state_in  = ST_TOTAL;
               end else begin
                  trades_in = count_inc[BUCKET_SIZE_BITS-1:0];
                  state_in  = req_last_trade ? ST_MEAN_START : ST_IDLE;
               end
            end
         end
         ST_TOTAL: begin
            total_in = buy_ff + sell_ff;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // take the magnitude and empty the bucket
            diff_in = buy_minus_sell[VOL_BITS] ? (sell_ff - buy_ff)
                                               : buy_minus_sell[VOL_BITS-1:0];
            buy_in  = '0;
            sell_in = '0;
            if (total_ff == '0) begin
               state_in = last_ff ? ST_MEAN_START : ST_IDLE;
            end else begin
               state_in = ST_FRAC_START;
            end
         end
         ST_FRAC_START: begin
            state_in = ST_FRAC_WAIT;
         end
         ST_FRAC_WAIT: begin
            if (div_status.done) begin
               imb_in     = imb_add[SUM_BITS] ? SUM_MAX : imb_add[SUM_BITS-1:0];
               counted_in = (counted_ff == COUNT_MAX) ? counted_ff
                                                      : counted_ff + COUNT_BITS'(1);
               state_in   = last_ff ? ST_MEAN_START : ST_IDLE;
            end
         end
         ST_MEAN_START: begin
            if (counted_ff == '0) begin
               mean_in  = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MEAN_WAIT;
            end
         end
         ST_MEAN_WAIT: begin
            if (div_status.done) begin
               mean_in  = div_quotient;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // load the result beat once the output register frees, then clear
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_vpin_in    = mean_ff;
               rsp_full_in    = full_ff;
               rsp_counted_in = counted_ff;
               rsp_too_few_in = (full_ff == '0);
               buy_in         = '0;
               sell_in        = '0;
               trades_in      = '0;
               imb_in         = '0;
               full_in        = '0;
               counted_in     = '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold sequencer state, bucket state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= BUCKET_SIZE_RESET;
         buy_ff       <= '0;
         sell_ff      <= '0;
         trades_ff    <= '0;
         imb_ff       <= '0;
         full_ff      <= '0;
         counted_ff   <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         buy_ff       <= buy_in;
         sell_ff      <= sell_in;
         trades_ff    <= trades_in;
         imb_ff       <= imb_in;
         full_ff      <= full_in;
         counted_ff   <= counted_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff       <= total_in;
      diff_ff        <= diff_in;
      mean_ff        <= mean_in;
      rsp_vpin_ff    <= rsp_vpin_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_counted_ff <= rsp_counted_in;
      rsp_too_few_ff <= rsp_too_few_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vpin            = rsp_vpin_ff;
   assign rsp_full_buckets    = rsp_full_ff;
   assign rsp_counted_buckets = rsp_counted_ff;
   assign rsp_too_few_trades  = rsp_too_few_ff;

   `VPIN_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_req.start, !div_status.busy)
   `VPIN_ASSERT_IMPLY(a_counted_le_full, clock, reset, 1'b1, counted_ff <= full_ff)
   `VPIN_ASSERT_IMPLY(a_too_few_is_zero, clock, reset, rsp_valid_ff && rsp_too_few_ff, rsp_full_ff == '0 && rsp_vpin_ff == '0)
   `VPIN_ASSERT_NEXT(a_emit_clears, clock, reset, state_ff == ST_EMIT && rsp_free, full_ff == '0 && imb_ff == '0 && rsp_valid_ff)

endmodule

`default_nettype wire

/* verif/vpin_order_flow_toxicity_unit_tb.sv */
// Self-checking testbench of the VPIN order flow toxicity unit.
`timescale 1ns / 1ps

module vpin_order_flow_toxicity_unit_tb;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;
   localparam logic MID_SEQ   = 1'b0;
   localparam logic END_SEQ   = 1'b1;

   localparam logic [vpin_pkg::QUANTITY_BITS-1:0]    QTY_MAX  = '1;
   localparam logic [vpin_pkg::BUCKET_SIZE_BITS-1:0] SIZE_MAX = '1;

   // Bucket close plus mean division, with margin.
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned RANDOM_TRADES = 1500;
   localparam int unsigned PHASE_TRADES  = 150;

   typedef struct packed {
      logic [vpin_pkg::QUOT_BITS-1:0]  vpin;
      logic [vpin_pkg::COUNT_BITS-1:0] full_buckets;
      logic [vpin_pkg::COUNT_BITS-1:0] counted_buckets;
      logic                            too_few_trades;
   } toxicity_result_type;

   // Predict toxicity results per trade and match them against result beats.
   class toxicity_scoreboard;
      logic [vpin_pkg::BUCKET_SIZE_BITS-1:0] size_setting;
      logic [63:0]                           buy_total;
      logic [63:0]                           sell_total;
      int unsigned                           trades_open;
      logic [vpin_pkg::SUM_BITS-1:0]         fraction_sum;
      logic [vpin_pkg::COUNT_BITS-1:0]       full_count;
      logic [vpin_pkg::COUNT_BITS-1:0]       counted_count;
      toxicity_result_type                   pending_results[$];
      int unsigned                           failures;

      function new();
         size_setting = vpin_pkg::BUCKET_SIZE_RESET;
         failures = 0;
         restart_sequence();
      endfunction

      function void restart_sequence();
         buy_total = '0;
         sell_total = '0;
         trades_open = 0;
         fraction_sum = '0;
         full_count = '0;
         counted_count = '0;
      endfunction

      // Close the open bucket: count it, and add its imbalance if it has volume.
      function void settle_bucket();
         logic [63:0] total;
         logic [63:0] diff;
         logic [63:0] fraction;
         logic [63:0] widened;
         total = buy_total + sell_total;
         if (full_count != vpin_pkg::COUNT_MAX) full_count++;
         if (total != 0) begin
            diff = (buy_total >= sell_total) ? buy_total - sell_total
                                             : sell_total - buy_total;
            fraction = (diff << vpin_pkg::FRACTION_BITS) / total;
            widened = 64'(fraction_sum) + fraction;
            if (widened > 64'(vpin_pkg::SUM_MAX)) fraction_sum = vpin_pkg::SUM_MAX;
            else fraction_sum = widened[vpin_pkg::SUM_BITS-1:0];
            if (counted_count != vpin_pkg::COUNT_MAX) counted_count++;
         end
         buy_total = '0;
         sell_total = '0;
         trades_open = 0;
      endfunction

      function void fail(string msg);
         failures++;
         if (failures <= 10) $display("%s", msg);
      endfunction

      // Advance the predicted state by one accepted trade beat.
      function void note_trade(logic side, logic [vpin_pkg::QUANTITY_BITS-1:0] quantity,
                               logic last);
         int unsigned         span;
         logic [63:0]         mean;
         toxicity_result_type want;
         span = (size_setting == 0) ? 1 : size_setting;
         if (side == SIDE_BUY) buy_total += quantity;
         else sell_total += quantity;
         trades_open++;
         if (trades_open >= span) settle_bucket();
         if (last == END_SEQ) begin
            mean = '0;
            if (counted_count != 0) begin
               mean = 64'(fraction_sum) / 64'(counted_count);
               if (mean > 64'(vpin_pkg::ONE_FRAC)) mean = 64'(vpin_pkg::ONE_FRAC);
            end
            want.vpin = mean[vpin_pkg::QUOT_BITS-1:0];
            want.full_buckets = full_count;
            want.counted_buckets = counted_count;
            want.too_few_trades = (full_count == 0);
            pending_results.insert(pending_results.size(), want);
            restart_sequence();
         end
      endfunction

      function void check_result(toxicity_result_type got);
         toxicity_result_type want;
         bit                  bad;
         if (pending_results.size() == 0) begin
            fail($sformatf("unexpected result beat: vpin %0d full %0d counted %0d few %0b",
                           got.vpin, got.full_buckets, got.counted_buckets,
                           got.too_few_trades));
            return;
         end
         want = pending_results[0];
         pending_results.delete(0);
         bad = (got.vpin !== want.vpin) || (got.full_buckets !== want.full_buckets) ||
               (got.counted_buckets !== want.counted_buckets) ||
               (got.too_few_trades !== want.too_few_trades);
         if (bad)
            fail($sformatf({"result mismatch: expected vpin %0d full %0d counted %0d few %0b,",
                            " got vpin %0d full %0d counted %0d few %0b"},
                           want.vpin, want.full_buckets, want.counted_buckets,
                           want.too_few_trades, got.vpin, got.full_buckets,
                           got.counted_buckets, got.too_few_trades));
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function void check_leftovers();
         if (pending_results.size() != 0)
            fail($sformatf("%0d expected results never arrived", pending_results.size()));
      endfunction
   endclass

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  csr_write_enable;
   logic [vpin_pkg::BUCKET_SIZE_BITS-1:0] csr_write_data;
   logic                                  req_valid;
   logic                                  req_stall;
   logic                                  req_trade_side;
   logic [vpin_pkg::QUANTITY_BITS-1:0]    req_trade_quantity;
   logic                                  req_last_trade;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [vpin_pkg::QUOT_BITS-1:0]        rsp_vpin;
   logic [vpin_pkg::COUNT_BITS-1:0]       rsp_full_buckets;
   logic [vpin_pkg::COUNT_BITS-1:0]       rsp_counted_buckets;
   logic                                  rsp_too_few_trades;

   toxicity_scoreboard sb;
   int unsigned        trades_sent = 0;
   int unsigned        stall_left = 0;
   bit                 sender_steady = 1'b0;
   bit                 receiver_steady = 1'b0;
   int unsigned        size_plan [9] = '{1, 0, 3, 2, 7, 50, 16, 1, 5};

   vpin_order_flow_toxicity_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_trade_side      (req_trade_side),
      .req_trade_quantity  (req_trade_quantity),
      .req_last_trade      (req_last_trade),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_vpin            (rsp_vpin),
      .rsp_full_buckets    (rsp_full_buckets),
      .rsp_counted_buckets (rsp_counted_buckets),
      .rsp_too_few_trades  (rsp_too_few_trades)
   );

   always #5 clock = ~clock;

   // Mostly short idle stretches, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [vpin_pkg::QUANTITY_BITS-1:0] random_quantity(bit zero_heavy);
      int unsigned pick;
      if (zero_heavy && $urandom_range(0, 3) != 0) return '0;
      pick = $urandom_range(0, 99);
      if (pick < 8) return '0;
      if (pick < 16) return QTY_MAX;
      if (pick < 40) return $urandom_range(1, 255);
      if (pick < 48) return 1;
      return $urandom();
   endfunction

   // Stall the result channel in random runs.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!receiver_steady && $urandom_range(0, 3) == 0) begin
         stall_left <= idle_length();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check every accepted result beat.
   always @(posedge clock) begin
      toxicity_result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.vpin = rsp_vpin;
         seen.full_buckets = rsp_full_buckets;
         seen.counted_buckets = rsp_counted_buckets;
         seen.too_few_trades = rsp_too_few_trades;
         sb.check_result(seen);
      end
   end

   // Drive one trade beat, hold it until accepted, then idle for the given gap.
   task automatic send_trade(input logic side, input logic [vpin_pkg::QUANTITY_BITS-1:0] quantity,
                             input logic last, input int unsigned gap);
      if (!req_valid) req_valid <= 1'b1;
      req_trade_side <= side;
      req_trade_quantity <= quantity;
      req_last_trade <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_trade(side, quantity, last);
      trades_sent++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected result has come and the divider is done.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_bucket_size(input logic [vpin_pkg::BUCKET_SIZE_BITS-1:0] size);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_write_data <= size;
      @(posedge clock);
      sb.size_setting = size;
      csr_write_enable <= 1'b0;
   endtask

   // Send a run of trades with a random side bias; end it with a last trade if asked.
   task automatic send_sequence(input int unsigned length, input logic closes);
      int unsigned bias;
      bit          zero_heavy;
      logic        side;
      int unsigned i;
      bias = $urandom_range(0, 3);
      zero_heavy = ($urandom_range(0, 7) == 0);
      for (i = 0; i < length; i++) begin
         case (bias)
            0: begin
               side = $urandom_range(0, 1);
            end
            1: begin
               side = SIDE_BUY;
            end
            2: begin
               side = SIDE_SELL;
            end
            default: begin
               side = ($urandom_range(0, 9) == 0) ? SIDE_SELL : SIDE_BUY;
            end
         endcase
         send_trade(side, random_quantity(zero_heavy),
                    (closes == END_SEQ && i == length - 1) ? END_SEQ : MID_SEQ,
                    sender_steady ? 0 : idle_length());
      end
   endtask

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int unsigned phase;
      int unsigned size;
      int unsigned span;
      int unsigned phase_end;
      int unsigned length;
      int unsigned i;

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_trade_side = SIDE_BUY;
      req_trade_quantity = '0;
      req_last_trade = MID_SEQ;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Too few trades at the reset bucket size.
      send_trade(SIDE_BUY, 32'd7, END_SEQ, idle_length());
      set_bucket_size(12'd2);
      // All buckets empty.
      send_trade(SIDE_SELL, '0, MID_SEQ, idle_length());
      send_trade(SIDE_BUY, '0, END_SEQ, idle_length());
      // Balanced bucket of maximum quantities, then a trailing partial bucket.
      send_trade(SIDE_BUY, QTY_MAX, MID_SEQ, idle_length());
      send_trade(SIDE_SELL, QTY_MAX, MID_SEQ, idle_length());
      send_trade(SIDE_BUY, 32'd5, END_SEQ, idle_length());
      // One-sided bucket, then the last trade closes a bucket.
      send_trade(SIDE_BUY, QTY_MAX, MID_SEQ, idle_length());
      send_trade(SIDE_BUY, 32'd1, MID_SEQ, idle_length());
      send_trade(SIDE_SELL, 32'd3, MID_SEQ, idle_length());
      send_trade(SIDE_BUY, 32'd1, END_SEQ, idle_length());
      send_trade(SIDE_SELL, QTY_MAX, MID_SEQ, idle_length());
      send_trade(SIDE_SELL, QTY_MAX, END_SEQ, idle_length());
      // Bucket size zero acts as one.
      set_bucket_size(12'd0);
      send_trade(SIDE_BUY, 32'd1, MID_SEQ, idle_length());
      send_trade(SIDE_SELL, 32'd2, MID_SEQ, idle_length());
      send_trade(SIDE_SELL, '0, END_SEQ, idle_length());
      // Lower the size while a bucket is open: it closes on the next trade.
      set_bucket_size(12'd3);
      send_trade(SIDE_BUY, 32'd10, MID_SEQ, idle_length());
      send_trade(SIDE_SELL, 32'd20, MID_SEQ, idle_length());
      set_bucket_size(12'd1);
      send_trade(SIDE_BUY, '0, END_SEQ, idle_length());

      // Random phases, each at its own bucket size.
      phase = 0;
      length = trades_sent;
      while (trades_sent < length + RANDOM_TRADES) begin
         size = (phase < 9) ? size_plan[phase] : $urandom_range(1, 40);
         set_bucket_size(size[vpin_pkg::BUCKET_SIZE_BITS-1:0]);
         sender_steady = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         span = (size == 0) ? 1 : size;
         phase_end = trades_sent + PHASE_TRADES;
         while (trades_sent < phase_end) begin
            i = $urandom_range(0, 4) * span + $urandom_range(0, span - 1);
            send_sequence((i == 0) ? 1 : i, END_SEQ);
         end
         // Leave a sequence open so the next size lands mid-bucket.
         if (phase[0]) send_sequence($urandom_range(1, 2 * span), MID_SEQ);
         phase++;
      end

      // Largest bucket size: a short sequence that never fills a bucket.
      set_bucket_size(SIZE_MAX);
      sender_steady = 1'b1;
      receiver_steady = 1'b0;
      send_sequence($urandom_range(1, 20), END_SEQ);

      drain_block();
      sb.check_leftovers();
      if (sb.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
